// ----- rtl/core/isrps_pkg.sv -----
// Shared types, constants and a helper function for the two-wire register slave
// with PD steering. No dependencies; imported by isrps_ctrl, isrps_dp and the top level.

package isrps_pkg;

    // Bus event codes carried with each input item.
    typedef enum logic [2:0] {
        EV_WR_START = 3'd0,
        EV_BYTE     = 3'd1,
        EV_STOP     = 3'd2,
        EV_RD_START = 3'd3,
        EV_RD_NEXT  = 3'd4
    } event_t;

    // Register file geometry.
    localparam int REG_DEPTH = 256;
    localparam int REG_AW    = 8;
    localparam int REG_DW    = 8;

    // Register addresses used by the steering step.
    localparam logic [REG_AW-1:0] ADDR_PWM_IDLE   = 8'd0;
    localparam logic [REG_AW-1:0] ADDR_DIST_HIGH  = 8'd1;
    localparam logic [REG_AW-1:0] ADDR_DIST_LOW   = 8'd2;
    localparam logic [REG_AW-1:0] ADDR_BASE_SPEED = 8'd3;
    localparam logic [REG_AW-1:0] ADDR_GAIN_PROP  = 8'd4;
    localparam logic [REG_AW-1:0] ADDR_GAIN_DERIV = 8'd5;

    // Write limit per transfer and counter width.
    localparam int               CNT_W     = 6;
    localparam logic [CNT_W-1:0] MAX_BYTES = 6'd40;

    // Reset values.
    localparam logic [7:0] READ_START_VALUE = 8'h33;
    localparam logic [7:0] RESET_SPEED      = 8'd100;
    localparam logic [7:0] RESET_GAIN_PROP  = 8'd50;
    localparam logic [7:0] RESET_GAIN_DERIV = 8'd23;
    localparam logic [7:0] RESET_PWM_B      = 8'd0;

    // Fixed-point constants: 0.0343 in Q16.16, and the saturation bound in
    // numerator units (200 times 655360).
    localparam logic signed [12:0] ERR_SCALE     = 13'sd2248;
    localparam int                 SAT_NUM_LIMIT = 131072000;
    localparam logic [7:0]         SPEED_LIMIT   = 8'd200;
    // Reciprocal of ten in 16 fraction bits, exact for quotients below 2000.
    localparam logic [12:0]        RECIP_TEN     = 13'd6554;

    // Datapath widths.
    localparam int ERR_W  = 28;
    localparam int MAG_W  = 27;
    localparam int DIFF_W = 29;
    localparam int P1_W   = 35;
    localparam int P2_W   = 38;
    localparam int SUM_W  = 40;

    // Register slot that a read fetches during a steering step.
    typedef enum logic [2:0] {
        SEL_HI,
        SEL_LO,
        SEL_SPD,
        SEL_GP,
        SEL_GD,
        SEL_R0
    } rd_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_HI,
        ST_RD_LO,
        ST_RD_SPD,
        ST_RD_GP,
        ST_RD_GD,
        ST_RD_R0,
        ST_ERR,
        ST_DIFF,
        ST_PROD,
        ST_SUM,
        ST_SAT,
        ST_PUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    exec;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    calc_err;
        logic    calc_diff;
        logic    calc_prod;
        logic    calc_sum;
        logic    calc_sat;
        logic    push;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_stop;
        logic out_free;
    } status_t;

    // Contents of a register file entry that has not been written since reset.
    function automatic logic [REG_DW-1:0] reg_reset_val(input logic [REG_AW-1:0] addr);
        logic [REG_DW-1:0] val;
        val = '0;
        if (addr == ADDR_BASE_SPEED)
        begin
            val = RESET_SPEED;
        end
        else if (addr == ADDR_GAIN_PROP)
        begin
            val = RESET_GAIN_PROP;
        end
        else if (addr == ADDR_GAIN_DERIV)
        begin
            val = RESET_GAIN_DERIV;
        end
        return val;
    endfunction

endpackage

// ----- rtl/core/isrps_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; has no dependencies.

module isrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/isrps_ctrl.sv -----
// Controller state machine: sequences event handling and the steering step.
// Depends on isrps_pkg.

module isrps_ctrl
    import isrps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = SEL_HI;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.is_stop ? ST_RD_HI : ST_PUSH;
            end
            ST_RD_HI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_HI;
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_LO;
                state_next = ST_RD_SPD;
            end
            ST_RD_SPD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SPD;
                state_next = ST_RD_GP;
            end
            ST_RD_GP:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_GP;
                state_next = ST_RD_GD;
            end
            ST_RD_GD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_GD;
                state_next = ST_RD_R0;
            end
            ST_RD_R0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_R0;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.calc_sat = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                // Hand the result over once the output register can take it.
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/isrps_dp.sv -----
// Datapath: register file, address and byte counters, read counter, PD
// arithmetic and the output register. Depends on isrps_pkg and isrps_ram.

module isrps_dp
    import isrps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  in_func,
    input  logic [7:0]  in_data,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser
);

    // Latched item.
    logic [2:0] func_reg;
    logic [7:0] data_reg;

    // Architectural state.
    logic [REG_AW-1:0]       waddr_reg,  waddr_next;
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;
    logic [7:0]              ctr_reg,    ctr_next;
    logic signed [ERR_W-1:0] prev_reg,   prev_next;
    logic [7:0]              pwm_a_reg,  pwm_a_next;
    logic [7:0]              pwm_b_reg,  pwm_b_next;
    logic [REG_DEPTH-1:0]    vld_reg;

    // Register file access.
    logic              ram_we;
    logic [REG_AW-1:0] ram_raddr;
    logic [REG_DW-1:0] ram_rdata;
    logic [REG_AW-1:0] raddr_q;
    logic              vld_q;
    logic              pend_reg;
    rd_sel_t           sel_q;
    logic [REG_DW-1:0] rd_value;

    // Operands fetched for the steering step.
    logic [7:0] hi_reg, lo_reg, spd_reg, gp_reg, gd_reg, r0_reg;

    // Arithmetic pipeline registers.
    logic signed [ERR_W-1:0]  err_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                     err_neg_reg, err_zero_reg;
    logic [P1_W-1:0]          p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    // Pending result fields.
    logic [7:0] rd_q;
    logic       rv_q;
    logic       upd_q;

    // Output register.
    logic        out_vld_reg;
    logic [23:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // Combinational arithmetic.
    logic signed [15:0]       dist_val;
    logic signed [ERR_W-1:0]  err_prod;
    logic signed [DIFF_W-1:0] diff_val;
    logic signed [ERR_W-1:0]  err_abs;
    logic signed [8:0]        gd_s;
    logic [P1_W-1:0]          p1_val;
    logic signed [P2_W-1:0]   p2_val;
    logic [27:0]              base_term;
    logic signed [SUM_W-1:0]  sum_val;
    logic [10:0]              quot_in;
    logic [23:0]              quot_prod;
    logic [7:0]               speed;

    assign status.is_stop  = (func_reg == EV_STOP);
    assign status.out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Map the read slot to its register address.
    always_comb
    begin
        case (cmd.rd_sel)
            SEL_HI:  ram_raddr = ADDR_DIST_HIGH;
            SEL_LO:  ram_raddr = ADDR_DIST_LOW;
            SEL_SPD: ram_raddr = ADDR_BASE_SPEED;
            SEL_GP:  ram_raddr = ADDR_GAIN_PROP;
            SEL_GD:  ram_raddr = ADDR_GAIN_DERIV;
            SEL_R0:  ram_raddr = ADDR_PWM_IDLE;
            default: ram_raddr = ADDR_PWM_IDLE;
        endcase
    end

    // Entries never written since reset read as their reset value.
    assign rd_value = vld_q ? ram_rdata : reg_reset_val(raddr_q);

    isrps_ram #(
        .WIDTH(REG_DW),
        .DEPTH(REG_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr_reg),
        .wdata(data_reg),
        .re   (cmd.rd_en),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Event handling: address, byte count and read counter.
    always_comb
    begin
        waddr_next = waddr_reg;
        cnt_next   = cnt_reg;
        ctr_next   = ctr_reg;
        ram_we     = 1'b0;
        if (cmd.exec)
        begin
            case (func_reg)
                EV_WR_START:
                begin
                    cnt_next = '0;
                end
                EV_BYTE:
                begin
                    // The first byte of a transfer sets the address; bytes
                    // past the limit are dropped.
                    if (cnt_reg < MAX_BYTES)
                    begin
                        if (cnt_reg == '0)
                        begin
                            waddr_next = data_reg;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            waddr_next = waddr_reg + REG_AW'(1);
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                EV_RD_START:
                begin
                    cnt_next = '0;
                    ctr_next = ctr_reg + 8'd1;
                end
                EV_RD_NEXT:
                begin
                    ctr_next = ctr_reg + 8'd1;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    // Error, difference, products and sum.
    always_comb
    begin
        dist_val  = $signed({hi_reg, lo_reg});
        err_prod  = ERR_W'(dist_val) * ERR_W'(ERR_SCALE);
        diff_val  = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        err_abs   = err_reg[ERR_W-1] ? -err_reg : err_reg;
        gd_s      = $signed({1'b0, gd_reg});
        p1_val    = P1_W'(mag_reg) * P1_W'(gp_reg);
        p2_val    = P2_W'(diff_reg) * P2_W'(gd_s);
        base_term = 28'({spd_reg, 19'b0}) + 28'({spd_reg, 17'b0});
        sum_val   = $signed({5'b0, p1_reg}) + SUM_W'(p2_reg) + $signed({12'b0, base_term});
    end

    // Truncating division by 655360 and saturation to the speed range.
    always_comb
    begin
        quot_in   = sum_reg[26:16];
        quot_prod = 24'(quot_in) * 24'(RECIP_TEN);
        if (sum_reg[SUM_W-1])
        begin
            speed = '0;
        end
        else if (sum_reg[SUM_W-2:0] >= (SUM_W-1)'(SAT_NUM_LIMIT))
        begin
            speed = SPEED_LIMIT;
        end
        else
        begin
            speed = quot_prod[23:16];
        end
    end

    // Steering outcome: the error sign picks the driven channel; a zero error changes neither.
    always_comb
    begin
        prev_next  = prev_reg;
        pwm_a_next = pwm_a_reg;
        pwm_b_next = pwm_b_reg;
        if (cmd.calc_diff)
        begin
            prev_next = err_reg;
        end
        if (cmd.calc_sat && !err_zero_reg)
        begin
            if (err_neg_reg)
            begin
                pwm_a_next = speed;
                pwm_b_next = r0_reg;
            end
            else
            begin
                pwm_a_next = r0_reg;
                pwm_b_next = speed;
            end
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waddr_reg   <= '0;
            cnt_reg     <= '0;
            ctr_reg     <= READ_START_VALUE;
            prev_reg    <= '0;
            pwm_a_reg   <= RESET_SPEED;
            pwm_b_reg   <= RESET_PWM_B;
            vld_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            waddr_reg <= waddr_next;
            cnt_reg   <= cnt_next;
            ctr_reg   <= ctr_next;
            prev_reg  <= prev_next;
            pwm_a_reg <= pwm_a_next;
            pwm_b_reg <= pwm_b_next;
            pend_reg  <= cmd.rd_en;
            if (ram_we)
            begin
                vld_reg[waddr_reg] <= 1'b1;
            end
            if (cmd.push)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= in_func;
            data_reg <= in_data;
        end
        if (cmd.rd_en)
        begin
            raddr_q <= ram_raddr;
            vld_q   <= vld_reg[ram_raddr];
            sel_q   <= cmd.rd_sel;
        end
        // Read data arrives in the cycle after the request.
        if (pend_reg)
        begin
            case (sel_q)
                SEL_HI:  hi_reg  <= rd_value;
                SEL_LO:  lo_reg  <= rd_value;
                SEL_SPD: spd_reg <= rd_value;
                SEL_GP:  gp_reg  <= rd_value;
                SEL_GD:  gd_reg  <= rd_value;
                SEL_R0:  r0_reg  <= rd_value;
                default: r0_reg  <= rd_value;
            endcase
        end
        if (cmd.exec)
        begin
            rv_q  <= (func_reg == EV_RD_START) || (func_reg == EV_RD_NEXT);
            rd_q  <= ((func_reg == EV_RD_START) || (func_reg == EV_RD_NEXT)) ? ctr_reg : 8'd0;
            upd_q <= 1'b0;
        end
        if (cmd.calc_err)
        begin
            err_reg <= err_prod;
        end
        if (cmd.calc_diff)
        begin
            diff_reg     <= diff_val;
            mag_reg      <= err_abs[MAG_W-1:0];
            err_neg_reg  <= err_reg[ERR_W-1];
            err_zero_reg <= (err_reg == '0);
        end
        if (cmd.calc_prod)
        begin
            p1_reg <= p1_val;
            p2_reg <= p2_val;
        end
        if (cmd.calc_sum)
        begin
            sum_reg <= sum_val;
        end
        if (cmd.calc_sat)
        begin
            upd_q <= !err_zero_reg;
        end
        if (cmd.push)
        begin
            out_data_reg <= {pwm_b_reg, pwm_a_reg, rd_q};
            out_user_reg <= {upd_q, rv_q};
        end
    end

endmodule

// ----- rtl/core/i2c_register_slave_pd_steering_top.sv -----
// Top level of the two-wire register slave with PD steering.
// Depends on isrps_pkg, isrps_ctrl and isrps_dp.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: func[2:0]; tdata: data_in[7:0]
//   m_*      out        tdata: read_data, pwm_a, pwm_b; tuser: read_valid, pwm_update
//
// A stop event goes through decode, six reads of the single register file read port,
// five arithmetic steps and hand-over to the output register; other events go through
// decode and hand-over only. The input takes no new item until hand-over is done.
// Reset sets the initial values at once; there is no clearing pass, as entries not yet
// written read their reset value. The next item is taken while a result still waits;
// a stalled output holds the block only when a second result is ready.

module i2c_register_slave_pd_steering_top
    import isrps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_data, [15:8] pwm_a, [23:16] pwm_b
    output logic [1:0]  m_tuser    // [0] read_valid, [1] pwm_update
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    isrps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Storage, arithmetic and output register.
    isrps_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_func (s_tuser),
        .in_data (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ----- rtl/core/isrps_chk.sv -----
// Port-level checker for the steering slave, bound to the top level.
// Depends only on the top level's ports.

module isrps_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Items are handled one at a time, so ready drops after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an acceptance");

    // A read answer never reports a PWM update.
    a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("read and PWM update flagged together");

    // Read data is zero when it carries no read answer.
    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("read data nonzero outside a read");

endmodule

bind i2c_register_slave_pd_steering_top isrps_chk u_chk (.*);
